@@ src/tmsb_pkg.sv @@
// Package for the text-mode screen buffer: types, constants and the microcode table.
`default_nettype none

package tmsb_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths and cell constants.
    localparam int          POS_W      = 16;
    localparam int          CURSOR_W   = 11;
    localparam int          STEP_W     = 5;
    localparam logic [7:0]  BLANK_CHAR = 8'h20;
    localparam logic [15:0] KEEP_COLOR = 16'hFF00;
    localparam logic [15:0] KEEP_BG    = 16'hF0FF;
    localparam logic [15:0] KEEP_FG    = 16'h0FFF;

    // Command codes.
    typedef enum logic [2:0] {
        CMD_PUT    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_SET_FG = 3'd3,
        CMD_SET_BG = 3'd4,
        CMD_SCROLL = 3'd5,
        CMD_CURSOR = 3'd6,
        CMD_READ   = 3'd7
    } cmd_code_t;

    // Request and response payloads.
    typedef struct packed {
        cmd_code_t   command;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [15:0] entry;
        logic [7:0]  color;
    } cmd_t;

    typedef struct packed {
        logic                status;
        logic [15:0]         read_value;
        logic [CURSOR_W-1:0] cursor_position;
    } rsp_t;

    typedef logic [STEP_W-1:0] step_t;

    // Sequencer jump kinds.
    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_GOTO     = 3'd1,
        J_DISPATCH = 3'd2,
        J_LOOP     = 3'd3,
        J_BAD      = 3'd4,
        J_END      = 3'd5,
        J_DONE     = 3'd6
    } jump_t;

    // Store address sources.
    typedef enum logic [1:0] {
        A_PTR = 2'd0,
        A_POS = 2'd1,
        A_DST = 2'd2
    } addr_sel_t;

    // Store write data sources.
    typedef enum logic [2:0] {
        WD_ZERO   = 3'd0,
        WD_ENTRY  = 3'd1,
        WD_BLANK  = 3'd2,
        WD_REMOVE = 3'd3,
        WD_FG     = 3'd4,
        WD_BG     = 3'd5,
        WD_COPY   = 3'd6
    } wdata_sel_t;

    // Sweep pointer operations.
    typedef enum logic [2:0] {
        P_HOLD    = 3'd0,
        P_INC     = 3'd1,
        P_ZERO    = 3'd2,
        P_COLS    = 3'd3,
        P_LASTROW = 3'd4
    } ptr_op_t;

    // One control word of the microprogram.
    typedef struct packed {
        jump_t      jump;
        step_t      target;
        logic       mem_rd;
        addr_sel_t  rd_sel;
        logic       mem_wr;
        addr_sel_t  wr_sel;
        wdata_sel_t wdata_sel;
        ptr_op_t    ptr_op;
        logic       cur_ld;
        logic       rv_ld;
    } ctrl_t;

    // Microprogram step addresses.
    localparam step_t S_RESET    = 5'd0;
    localparam step_t S_IDLE     = 5'd1;
    localparam step_t S_PUT_CHK  = 5'd2;
    localparam step_t S_PUT_WR   = 5'd3;
    localparam step_t S_RM_CHK   = 5'd4;
    localparam step_t S_RM_RD    = 5'd5;
    localparam step_t S_RM_WR    = 5'd6;
    localparam step_t S_CLR      = 5'd7;
    localparam step_t S_CLR_END  = 5'd8;
    localparam step_t S_FG_RD    = 5'd9;
    localparam step_t S_FG_WR    = 5'd10;
    localparam step_t S_FG_END   = 5'd11;
    localparam step_t S_BG_RD    = 5'd12;
    localparam step_t S_BG_WR    = 5'd13;
    localparam step_t S_BG_END   = 5'd14;
    localparam step_t S_SC_INIT  = 5'd15;
    localparam step_t S_SC_CHK   = 5'd16;
    localparam step_t S_SC_RD    = 5'd17;
    localparam step_t S_SC_WR    = 5'd18;
    localparam step_t S_SC_FILL0 = 5'd19;
    localparam step_t S_SC_FILL  = 5'd20;
    localparam step_t S_SC_END   = 5'd21;
    localparam step_t S_CUR_CHK  = 5'd22;
    localparam step_t S_CUR_SET  = 5'd23;
    localparam step_t S_RD_CHK   = 5'd24;
    localparam step_t S_RD_RD    = 5'd25;
    localparam step_t S_RD_CAP   = 5'd26;
    localparam step_t S_DONE     = 5'd27;

    localparam ctrl_t CTRL_NOP = '{
        jump:      J_NEXT,
        target:    S_IDLE,
        mem_rd:    1'b0,
        rd_sel:    A_PTR,
        mem_wr:    1'b0,
        wr_sel:    A_PTR,
        wdata_sel: WD_ZERO,
        ptr_op:    P_HOLD,
        cur_ld:    1'b0,
        rv_ld:     1'b0
    };

    // Entry step of each command.
    function automatic step_t dispatch(input cmd_code_t code);
        step_t s;
        unique case (code)
            CMD_PUT:    s = S_PUT_CHK;
            CMD_REMOVE: s = S_RM_CHK;
            CMD_CLEAR:  s = S_CLR;
            CMD_SET_FG: s = S_FG_RD;
            CMD_SET_BG: s = S_BG_RD;
            CMD_SCROLL: s = S_SC_INIT;
            CMD_CURSOR: s = S_CUR_CHK;
            CMD_READ:   s = S_RD_CHK;
            default:    s = S_IDLE;
        endcase
        return s;
    endfunction

    // Microprogram read-only table.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t c;
        c = CTRL_NOP;
        unique case (step)
            // Clearing pass after reset.
            S_RESET:
            begin
                c.mem_wr = 1'b1; c.wdata_sel = WD_ZERO;
                c.ptr_op = P_INC; c.jump = J_LOOP; c.target = S_RESET;
            end
            S_IDLE:
            begin
                c.jump = J_DISPATCH; c.ptr_op = P_ZERO;
            end
            // Put.
            S_PUT_CHK:
            begin
                c.jump = J_BAD; c.target = S_DONE;
            end
            S_PUT_WR:
            begin
                c.mem_wr = 1'b1; c.wr_sel = A_POS; c.wdata_sel = WD_ENTRY;
                c.jump = J_GOTO; c.target = S_DONE;
            end
            // Remove.
            S_RM_CHK:
            begin
                c.jump = J_BAD; c.target = S_DONE;
            end
            S_RM_RD:
            begin
                c.mem_rd = 1'b1; c.rd_sel = A_POS;
            end
            S_RM_WR:
            begin
                c.mem_wr = 1'b1; c.wr_sel = A_POS; c.wdata_sel = WD_REMOVE;
                c.jump = J_GOTO; c.target = S_DONE;
            end
            // Clear.
            S_CLR:
            begin
                c.mem_wr = 1'b1; c.wdata_sel = WD_BLANK;
                c.ptr_op = P_INC; c.jump = J_LOOP; c.target = S_CLR;
            end
            S_CLR_END:
            begin
                c.jump = J_GOTO; c.target = S_DONE;
            end
            // Recolor foreground.
            S_FG_RD:
            begin
                c.mem_rd = 1'b1;
            end
            S_FG_WR:
            begin
                c.mem_wr = 1'b1; c.wdata_sel = WD_FG;
                c.ptr_op = P_INC; c.jump = J_LOOP; c.target = S_FG_RD;
            end
            S_FG_END:
            begin
                c.jump = J_GOTO; c.target = S_DONE;
            end
            // Recolor background.
            S_BG_RD:
            begin
                c.mem_rd = 1'b1;
            end
            S_BG_WR:
            begin
                c.mem_wr = 1'b1; c.wdata_sel = WD_BG;
                c.ptr_op = P_INC; c.jump = J_LOOP; c.target = S_BG_RD;
            end
            S_BG_END:
            begin
                c.jump = J_GOTO; c.target = S_DONE;
            end
            // Scroll: copy each line up, then blank the bottom line.
            S_SC_INIT:
            begin
                c.ptr_op = P_COLS;
            end
            S_SC_CHK:
            begin
                c.jump = J_END; c.target = S_SC_FILL0;
            end
            S_SC_RD:
            begin
                c.mem_rd = 1'b1;
            end
            S_SC_WR:
            begin
                c.mem_wr = 1'b1; c.wr_sel = A_DST; c.wdata_sel = WD_COPY;
                c.ptr_op = P_INC; c.jump = J_LOOP; c.target = S_SC_RD;
            end
            S_SC_FILL0:
            begin
                c.ptr_op = P_LASTROW;
            end
            S_SC_FILL:
            begin
                c.mem_wr = 1'b1; c.wdata_sel = WD_BLANK;
                c.ptr_op = P_INC; c.jump = J_LOOP; c.target = S_SC_FILL;
            end
            S_SC_END:
            begin
                c.jump = J_GOTO; c.target = S_DONE;
            end
            // Cursor move.
            S_CUR_CHK:
            begin
                c.jump = J_BAD; c.target = S_DONE;
            end
            S_CUR_SET:
            begin
                c.cur_ld = 1'b1; c.jump = J_GOTO; c.target = S_DONE;
            end
            // Cell read.
            S_RD_CHK:
            begin
                c.jump = J_BAD; c.target = S_DONE;
            end
            S_RD_RD:
            begin
                c.mem_rd = 1'b1; c.rd_sel = A_POS;
            end
            S_RD_CAP:
            begin
                c.rv_ld = 1'b1; c.jump = J_GOTO; c.target = S_DONE;
            end
            // Hand the response over once the output register is free.
            S_DONE:
            begin
                c.jump = J_DONE; c.target = S_IDLE;
            end
            default:
            begin
                c.jump = J_GOTO; c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/text_mode_screen_buffer.sv @@
// Text-mode screen buffer: microcoded sequencer over a single-port cell store.
`default_nettype none

// Channel   Handshake             Payload
// cmd       cmd_valid, cmd_stall  tmsb_pkg::cmd_t (command, column, row, entry, color)
// rsp       rsp_valid, rsp_stall  tmsb_pkg::rsp_t (status, read_value, cursor_position)
//
// Each request is worked by a microprogram over one store port that either reads
// or writes in a cycle. A new request is not taken until the sequencer is back in
// its idle step. After reset a clearing pass zeroes the store with cmd_stall high.
// A finished response waits in an output register; while that one is stalled, the
// next waits in its last step.

module text_mode_screen_buffer #(
    parameter int COLUMNS = tmsb_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmsb_pkg::DEF_ROWS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire tmsb_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output tmsb_pkg::rsp_t      rsp
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PTR_W  = $clog2(CELLS + 1);

    // Sequencer state.
    tmsb_pkg::step_t step_reg, step_next;
    tmsb_pkg::ctrl_t cw;
    logic [PTR_W-1:0] ptr_reg, ptr_next, ptr_inc, ptr_dst;

    // Request fields held for the length of a command.
    logic [tmsb_pkg::POS_W-1:0]    pos_reg;
    logic [15:0]                   entry_reg;
    logic [7:0]                    color_reg;
    logic                          err_reg;
    logic [15:0]                   readv_reg;
    logic [tmsb_pkg::CURSOR_W-1:0] cursor_reg;

    // Store and its port.
    logic [15:0]       mem [CELLS];
    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [15:0]       wr_data;

    logic                       accept;
    logic                       out_free;
    logic                       coord_cmd;
    logic                       in_range;
    logic [tmsb_pkg::POS_W-1:0] pos_calc;
    tmsb_pkg::rsp_t             rsp_reg;
    logic                       rsp_valid_reg;

    assign cw        = tmsb_pkg::ucode(step_reg);
    assign cmd_stall = (step_reg != tmsb_pkg::S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign ptr_inc   = ptr_reg + PTR_W'(1);
    assign ptr_dst   = ptr_reg - PTR_W'(COLUMNS);

    // Linear position and bounds check of the incoming request.
    assign pos_calc  = tmsb_pkg::POS_W'(cmd.row) * tmsb_pkg::POS_W'(COLUMNS)
                     + tmsb_pkg::POS_W'(cmd.column);
    assign in_range  = (9'(cmd.column) < 9'(COLUMNS)) && (9'(cmd.row) < 9'(ROWS));
    assign coord_cmd = (cmd.command == tmsb_pkg::CMD_PUT)
                    || (cmd.command == tmsb_pkg::CMD_REMOVE)
                    || (cmd.command == tmsb_pkg::CMD_CURSOR)
                    || (cmd.command == tmsb_pkg::CMD_READ);

    // Next step from the control word's jump kind.
    always_comb
    begin
        step_next = step_reg;
        unique case (cw.jump)
            tmsb_pkg::J_NEXT:     step_next = step_reg + tmsb_pkg::STEP_W'(1);
            tmsb_pkg::J_GOTO:     step_next = cw.target;
            tmsb_pkg::J_DISPATCH:
            begin
                if (accept)
                begin
                    step_next = tmsb_pkg::dispatch(cmd.command);
                end
            end
            tmsb_pkg::J_LOOP:
            begin
                step_next = (ptr_inc != PTR_W'(CELLS)) ? cw.target
                                                       : step_reg + tmsb_pkg::STEP_W'(1);
            end
            tmsb_pkg::J_BAD:
            begin
                step_next = err_reg ? cw.target : step_reg + tmsb_pkg::STEP_W'(1);
            end
            tmsb_pkg::J_END:
            begin
                step_next = (ptr_reg == PTR_W'(CELLS)) ? cw.target
                                                       : step_reg + tmsb_pkg::STEP_W'(1);
            end
            tmsb_pkg::J_DONE:
            begin
                if (out_free)
                begin
                    step_next = cw.target;
                end
            end
            default:              step_next = tmsb_pkg::S_IDLE;
        endcase
    end

    // Sweep pointer update.
    always_comb
    begin
        case (cw.ptr_op)
            tmsb_pkg::P_INC:     ptr_next = ptr_inc;
            tmsb_pkg::P_ZERO:    ptr_next = '0;
            tmsb_pkg::P_COLS:    ptr_next = PTR_W'(COLUMNS);
            tmsb_pkg::P_LASTROW: ptr_next = PTR_W'(CELLS - COLUMNS);
            default:             ptr_next = ptr_reg;
        endcase
    end

    // Store addresses.
    always_comb
    begin
        case (cw.rd_sel)
            tmsb_pkg::A_POS: rd_addr = pos_reg[ADDR_W-1:0];
            default:         rd_addr = ptr_reg[ADDR_W-1:0];
        endcase
        case (cw.wr_sel)
            tmsb_pkg::A_POS: wr_addr = pos_reg[ADDR_W-1:0];
            tmsb_pkg::A_DST: wr_addr = ptr_dst[ADDR_W-1:0];
            default:         wr_addr = ptr_reg[ADDR_W-1:0];
        endcase
    end

    // Store write data.
    always_comb
    begin
        case (cw.wdata_sel)
            tmsb_pkg::WD_ENTRY:  wr_data = entry_reg;
            tmsb_pkg::WD_BLANK:  wr_data = {color_reg, tmsb_pkg::BLANK_CHAR};
            tmsb_pkg::WD_REMOVE:
            begin
                wr_data = (rd_data_reg & tmsb_pkg::KEEP_COLOR) | 16'(tmsb_pkg::BLANK_CHAR);
            end
            tmsb_pkg::WD_FG:
            begin
                wr_data = (rd_data_reg & tmsb_pkg::KEEP_BG) | {4'h0, color_reg[3:0], 8'h00};
            end
            tmsb_pkg::WD_BG:
            begin
                wr_data = (rd_data_reg & tmsb_pkg::KEEP_FG) | {color_reg[3:0], 12'h000};
            end
            tmsb_pkg::WD_COPY:   wr_data = rd_data_reg;
            default:             wr_data = '0;
        endcase
    end

    // Cell store with registered read data.
    always_ff @(posedge clk)
    begin
        if (cw.mem_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cw.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tmsb_pkg::S_RESET;
            ptr_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            ptr_reg  <= ptr_next;
        end
    end

    // Request fields, captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg   <= pos_calc;
            entry_reg <= cmd.entry;
            color_reg <= cmd.color;
            err_reg   <= coord_cmd && !in_range;
        end
    end

    // Read value: zero unless a read command loads it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            readv_reg <= '0;
        end
        else if (cw.rv_ld)
        begin
            readv_reg <= rd_data_reg;
        end
    end

    // Cursor register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else if (cw.cur_ld)
        begin
            cursor_reg <= pos_reg[tmsb_pkg::CURSOR_W-1:0];
        end
    end

    // Response output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((cw.jump == tmsb_pkg::J_DONE) && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cw.jump == tmsb_pkg::J_DONE) && out_free)
        begin
            rsp_reg.status          <= err_reg;
            rsp_reg.read_value      <= readv_reg;
            rsp_reg.cursor_position <= cursor_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ tb/text_mode_screen_buffer_tb.sv @@
// Testbench for the text-mode screen buffer: a directed table, then random commands.
module text_mode_screen_buffer_tb;

    localparam int COLUMNS    = tmsb_pkg::DEF_COLUMNS;
    localparam int ROWS       = tmsb_pkg::DEF_ROWS;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int CURSOR_W   = tmsb_pkg::CURSOR_W;
    localparam int RANDOM_CMDS = 1200;
    // A bulk command and the clearing pass each walk the whole screen, well inside this limit.
    localparam int IDLE_LIMIT = 10 * CELLS;
    localparam int SETTLE_CYCLES = 12;

    // One row of the directed table; typed rows carry their response written out.
    typedef struct {
        tmsb_pkg::cmd_t req;
        bit             typed;
        tmsb_pkg::rsp_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    tmsb_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    tmsb_pkg::rsp_t rsp;

    // Shadow copy of the screen and cursor, and the responses still owed.
    logic [15:0] screen_shadow [CELLS];
    logic [CURSOR_W-1:0] cursor_shadow;
    tmsb_pkg::rsp_t pending_responses [$];
    plan_row_t directed_plan [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int stall_draw;
    bit calm = 1'b0;
    logic [7:0] last_column = 8'd0;
    logic [7:0] last_row = 8'd0;

    text_mode_screen_buffer #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    // Clock.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one command to the shadow screen and return the response it should give.
    function automatic tmsb_pkg::rsp_t apply_command(input tmsb_pkg::cmd_t req);
        tmsb_pkg::rsp_t r;
        int pos;
        logic fits;
        r = '0;
        fits = (req.column < COLUMNS) && (req.row < ROWS);
        pos = req.row * COLUMNS + req.column;
        case (req.command)
            tmsb_pkg::CMD_PUT:
                if (fits) screen_shadow[pos] = req.entry;
                else r.status = 1'b1;
            tmsb_pkg::CMD_REMOVE:
                if (fits) screen_shadow[pos] = {screen_shadow[pos][15:8], tmsb_pkg::BLANK_CHAR};
                else r.status = 1'b1;
            tmsb_pkg::CMD_CLEAR:
                for (int i = 0; i < CELLS; i++)
                    screen_shadow[i] = {req.color, tmsb_pkg::BLANK_CHAR};
            tmsb_pkg::CMD_SET_FG:
                for (int i = 0; i < CELLS; i++)
                    screen_shadow[i][11:8] = req.color[3:0];
            tmsb_pkg::CMD_SET_BG:
                for (int i = 0; i < CELLS; i++)
                    screen_shadow[i][15:12] = req.color[3:0];
            tmsb_pkg::CMD_SCROLL:
            begin
                for (int i = COLUMNS; i < CELLS; i++)
                    screen_shadow[i - COLUMNS] = screen_shadow[i];
                for (int i = CELLS - COLUMNS; i < CELLS; i++)
                    screen_shadow[i] = {req.color, tmsb_pkg::BLANK_CHAR};
            end
            tmsb_pkg::CMD_CURSOR:
                if (fits) cursor_shadow = pos[CURSOR_W-1:0];
                else r.status = 1'b1;
            default:
                if (fits) r.read_value = screen_shadow[pos];
                else r.status = 1'b1;
        endcase
        r.cursor_position = cursor_shadow;
        return r;
    endfunction

    // Sender gap: mostly none, some short, a few long.
    function automatic int pick_gap();
        int draw;
        draw = $urandom_range(0, 99);
        if (calm || draw < 60)
            return 0;
        if (draw < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Coordinate: in range, on an edge, reusing the last put, or anything at all.
    function automatic logic [7:0] pick_coord(input int limit, input logic [7:0] last);
        int draw;
        draw = $urandom_range(0, 99);
        if (draw < 12)
            return 8'($urandom_range(0, 255));
        if (draw < 22)
        begin
            case ($urandom_range(0, 3))
                0: return 8'd0;
                1: return 8'(limit - 1);
                2: return 8'(limit);
                default: return 8'd255;
            endcase
        end
        if (draw < 55)
            return last;
        return 8'($urandom_range(0, limit - 1));
    endfunction

    // Random request; bulk commands are kept rare since each walks the whole screen.
    function automatic tmsb_pkg::cmd_t random_command();
        tmsb_pkg::cmd_t req;
        int draw;
        draw = $urandom_range(0, 99);
        if (draw < 35) req.command = tmsb_pkg::CMD_PUT;
        else if (draw < 47) req.command = tmsb_pkg::CMD_REMOVE;
        else if (draw < 80) req.command = tmsb_pkg::CMD_READ;
        else if (draw < 95) req.command = tmsb_pkg::CMD_CURSOR;
        else if (draw < 96) req.command = tmsb_pkg::CMD_CLEAR;
        else if (draw < 97) req.command = tmsb_pkg::CMD_SET_FG;
        else if (draw < 98) req.command = tmsb_pkg::CMD_SET_BG;
        else req.command = tmsb_pkg::CMD_SCROLL;
        req.column = pick_coord(COLUMNS, last_column);
        req.row = pick_coord(ROWS, last_row);
        req.entry = 16'($urandom_range(0, 65535));
        req.color = 8'($urandom_range(0, 255));
        return req;
    endfunction

    task automatic add_row(input tmsb_pkg::cmd_code_t op, input int column, input int row,
                           input int entry, input int color, input int typed = 0,
                           input int status = 0, input int read_value = 0,
                           input int cursor_position = 0);
        plan_row_t p;
        p.req.command = op;
        p.req.column = 8'(column);
        p.req.row = 8'(row);
        p.req.entry = 16'(entry);
        p.req.color = 8'(color);
        p.typed = (typed != 0);
        p.want.status = (status != 0);
        p.want.read_value = 16'(read_value);
        p.want.cursor_position = CURSOR_W'(cursor_position);
        directed_plan.push_back(p);
    endtask

    // Drive one request, hold it until taken, then record what it should return.
    task automatic send_request(input tmsb_pkg::cmd_t req, input bit typed,
                                input tmsb_pkg::rsp_t want);
        tmsb_pkg::rsp_t predicted;
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= req;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        predicted = apply_command(req);
        pending_responses.push_back(typed ? want : predicted);
    endtask

    // Hold off new requests until every outstanding response is back.
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_responses.size() != 0) @(posedge clk);
    endtask

    // Response side: random stall bursts and field-by-field checking.
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("unexpected response: status %0d read_value %h cursor_position %0d",
                       rsp.status, rsp.read_value, rsp.cursor_position);
                mismatches++;
            end
            else
            begin
                if (rsp.status !== pending_responses[0].status)
                begin
                    $error("status: expected %0d, got %0d",
                           pending_responses[0].status, rsp.status);
                    mismatches++;
                end
                if (rsp.read_value !== pending_responses[0].read_value)
                begin
                    $error("read_value: expected %h, got %h",
                           pending_responses[0].read_value, rsp.read_value);
                    mismatches++;
                end
                if (rsp.cursor_position !== pending_responses[0].cursor_position)
                begin
                    $error("cursor_position: expected %0d, got %0d",
                           pending_responses[0].cursor_position, rsp.cursor_position);
                    mismatches++;
                end
                void'(pending_responses.pop_front());
            end
        end
        if (calm)
        begin
            stall_left <= 0;
            rsp_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            stall_draw = $urandom_range(0, 99);
            if (stall_draw < 20)
            begin
                stall_left <= $urandom_range(0, 2);
                rsp_stall <= 1'b1;
            end
            else if (stall_draw < 23)
            begin
                stall_left <= $urandom_range(15, 40);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("text_mode_screen_buffer test failed");
                $finish;
            end
        end
    end

    // Stimulus.
    initial
    begin
        tmsb_pkg::rsp_t none;
        tmsb_pkg::cmd_t req;
        none = '0;
        for (int i = 0; i < CELLS; i++)
            screen_shadow[i] = 16'h0000;
        cursor_shadow = '0;

        // Directed table: reset contents, corners, every command, refusals.
        add_row(tmsb_pkg::CMD_READ,   0,   0,   16'h0000, 8'h00, 1, 0, 0, 0);
        add_row(tmsb_pkg::CMD_READ,   79,  24,  16'h0000, 8'h00, 1, 0, 0, 0);
        add_row(tmsb_pkg::CMD_PUT,    0,   0,   16'hFFFF, 8'hFF);
        add_row(tmsb_pkg::CMD_PUT,    79,  24,  16'h1234, 8'h00);
        add_row(tmsb_pkg::CMD_PUT,    80,  0,   16'hFFFF, 8'h00, 1, 1, 0, 0);
        add_row(tmsb_pkg::CMD_PUT,    0,   25,  16'hFFFF, 8'h00, 1, 1, 0, 0);
        add_row(tmsb_pkg::CMD_PUT,    255, 255, 16'hFFFF, 8'hFF, 1, 1, 0, 0);
        add_row(tmsb_pkg::CMD_READ,   0,   0,   16'h0000, 8'h00);
        add_row(tmsb_pkg::CMD_REMOVE, 0,   0,   16'h0000, 8'h00);
        add_row(tmsb_pkg::CMD_REMOVE, 80,  24,  16'h0000, 8'h00, 1, 1, 0, 0);
        add_row(tmsb_pkg::CMD_READ,   0,   0,   16'h0000, 8'h00);
        add_row(tmsb_pkg::CMD_CURSOR, 79,  24,  16'h0000, 8'h00);
        add_row(tmsb_pkg::CMD_CURSOR, 255, 0,   16'h0000, 8'h00, 1, 1, 0, 1999);
        add_row(tmsb_pkg::CMD_READ,   0,   255, 16'h0000, 8'h00, 1, 1, 0, 1999);
        add_row(tmsb_pkg::CMD_CLEAR,  0,   0,   16'h0000, 8'hA5);
        add_row(tmsb_pkg::CMD_READ,   5,   5,   16'h0000, 8'h00);
        add_row(tmsb_pkg::CMD_SET_FG, 200, 200, 16'h0000, 8'hF3);
        add_row(tmsb_pkg::CMD_SET_BG, 0,   0,   16'h0000, 8'h0C);
        add_row(tmsb_pkg::CMD_READ,   5,   5,   16'h0000, 8'h00);
        add_row(tmsb_pkg::CMD_PUT,    3,   1,   16'hABCD, 8'h00);
        add_row(tmsb_pkg::CMD_SCROLL, 0,   0,   16'h0000, 8'h5A);
        add_row(tmsb_pkg::CMD_READ,   3,   0,   16'h0000, 8'h00);
        add_row(tmsb_pkg::CMD_READ,   0,   24,  16'h0000, 8'h00);
        add_row(tmsb_pkg::CMD_CURSOR, 0,   0,   16'h0000, 8'h00);
        add_row(tmsb_pkg::CMD_READ,   80,  25,  16'h0000, 8'h00, 1, 1, 0, 0);

        // Reset, released at a clock edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
        drain();

        // Random commands, with a stretch free of gaps and stalls and one more drain.
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            calm = (n >= 300) && (n < 500);
            if (n == 700)
                drain();
            req = random_command();
            if (req.command == tmsb_pkg::CMD_PUT)
            begin
                last_column = req.column;
                last_row = req.row;
            end
            send_request(req, 1'b0, none);
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_responses.size() != 0)
        begin
            $error("%0d responses never arrived", pending_responses.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("text_mode_screen_buffer test passed");
        else
            $display("text_mode_screen_buffer test failed");
        $finish;
    end

endmodule
